// ===== rtl/ftr_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// ftr_pkg: shared constants and tables
// Angle table, status codes and register addresses.
// ---------------------------------------------------------------------------
package ftr_pkg;

  localparam int CordicStepsDef = 16;
  localparam int PosWidthDef    = 24;
  localparam int AngleWidthDef  = 16;
  localparam int TabLen         = 24;

  localparam logic signed [15:0] PiQ12    = 16'sd12868;
  localparam logic signed [16:0] TwoPiQ12 = 17'sd25736;
  localparam longint PiQ30 = 64'd3373259426;

  localparam logic [1:0] StatSteer  = 2'd0;
  localparam logic [1:0] StatArrive = 2'd1;
  localparam logic [1:0] StatZero   = 2'd2;

  localparam logic [2:0] RegMaxAccel = 3'd0;
  localparam logic [2:0] RegMaxSpin  = 3'd1;
  localparam logic [2:0] RegArrive   = 3'd2;
  localparam logic [2:0] RegSlow     = 3'd3;
  localparam logic [2:0] RegTtt      = 3'd4;

  function automatic longint atan_q30(input int i);
    case (i)
      0: return 843314857;   1: return 497837829;   2: return 263043837;
      3: return 133525159;   4: return 67021687;    5: return 33543516;
      6: return 16775851;    7: return 8388437;     8: return 4194283;
      9: return 2097149;     10: return 1048576;    11: return 524288;
      12: return 262144;     13: return 131072;     14: return 65536;
      15: return 32768;      16: return 16384;      17: return 8192;
      18: return 4096;       19: return 2048;       20: return 1024;
      21: return 512;        22: return 256;        23: return 128;
      default: return 0;
    endcase
  endfunction

  // round-half-up shift of a positive constant
  function automatic longint rshift_c(input longint v, input int s);
    if (s == 0) return v;
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/ftr_cordic_cell.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// ftr_cordic_cell: one vectoring CORDIC step
// Rotates (x, y) toward the x axis by a fixed angle and hands the word on.
// ---------------------------------------------------------------------------
module ftr_cordic_cell import ftr_pkg::*; #(
  parameter int XW    = 58,
  parameter int ZW    = 20,
  parameter int SHIFT = 0,
  parameter int AngleWidth = AngleWidthDef,
  parameter int SW    = 64
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  vld_i,
  input  wire signed [XW-1:0]  x_i,
  input  wire signed [XW-1:0]  y_i,
  input  wire signed [ZW-1:0]  z_i,
  input  wire        [SW-1:0]  side_i,
  output logic                 vld_o,
  output logic signed [XW-1:0] x_o,
  output logic signed [XW-1:0] y_o,
  output logic signed [ZW-1:0] z_o,
  output logic       [SW-1:0]  side_o
);

  localparam longint ACon = (SHIFT < TabLen) ?
      rshift_c(atan_q30(SHIFT), 30 - AngleWidth) : 0;
  localparam logic signed [ZW-1:0] AStep = ZW'(ACon);

  logic vld_q;
  logic signed [XW-1:0] x_q, y_q;
  logic signed [ZW-1:0] z_q;
  logic [SW-1:0] side_q;

  // rotate by the sign of y
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    side_q <= side_i;
    if (y_i < 0) begin
      x_q <= x_i - (y_i >>> SHIFT);
      y_q <= y_i + (x_i >>> SHIFT);
      z_q <= z_i - AStep;
    end else begin
      x_q <= x_i + (y_i >>> SHIFT);
      y_q <= y_i - (x_i >>> SHIFT);
      z_q <= z_i + AStep;
    end
  end

  assign vld_o = vld_q;
  assign x_o = x_q;
  assign y_o = y_q;
  assign z_o = z_q;
  assign side_o = side_q;

endmodule
`default_nettype wire

// ===== rtl/ftr_div_cell.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// ftr_div_cell: one restoring division step
// Shifts in one dividend bit, subtracts the divisor if it fits.
// ---------------------------------------------------------------------------
module ftr_div_cell import ftr_pkg::*; #(
  parameter int NW = 30,
  parameter int DW = 15,
  parameter int SW = 64
) (
  input  wire           clk_i,
  input  wire           rst_ni,
  input  wire           vld_i,
  input  wire  [NW-1:0] num_i,
  input  wire  [DW:0]   rem_i,
  input  wire  [DW-1:0] den_i,
  input  wire  [SW-1:0] side_i,
  output logic          vld_o,
  output logic [NW-1:0] num_o,
  output logic [DW:0]   rem_o,
  output logic [DW-1:0] den_o,
  output logic [SW-1:0] side_o
);

  logic vld_q;
  logic [NW-1:0] num_q;
  logic [DW:0] rem_q;
  logic [DW-1:0] den_q;
  logic [SW-1:0] side_q;
  logic [DW+1:0] trial;

  assign trial = {rem_i, num_i[NW-1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_i;
    end
  end

  // quotient bit enters at the bottom of num
  always_ff @(posedge clk_i) begin
    den_q <= den_i;
    side_q <= side_i;
    if (trial >= {2'b0, den_i}) begin
      rem_q <= (DW+1)'(trial - {2'b0, den_i});
      num_q <= {num_i[NW-2:0], 1'b1};
    end else begin
      rem_q <= trial[DW:0];
      num_q <= {num_i[NW-2:0], 1'b0};
    end
  end

  assign vld_o = vld_q;
  assign num_o = num_q;
  assign rem_o = rem_q;
  assign den_o = den_q;
  assign side_o = side_q;

endmodule
`default_nettype wire

// ===== rtl/face_target_heading_regulator_unit.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// face_target_heading_regulator_unit: turn-to-face steering
// CORDIC cell chain for the heading, then two divider cell chains for the
// spin ramp and the acceleration.
// ---------------------------------------------------------------------------
// channel   | ports                               | handshake
// input     | agent_*_i goal_*_i agent_*_i        | start_i & !busy_o
// result    | angular_accel_o wanted_heading_o .. | done_o, one cycle
// config    | psel/penable/pwrite/paddr/pwdata    | APB, pready high
//
// One word per cycle; the path runs through the CORDIC chain, a 32-step and a
// 29-step divider chain and the output register.
// busy_o is always low. Reset clears valid flags and loads register defaults.
// Results cannot be stalled.
module face_target_heading_regulator_unit import ftr_pkg::*; #(
  parameter int CORDIC_STEPS = CordicStepsDef,
  parameter int POS_WIDTH    = PosWidthDef,
  parameter int ANGLE_WIDTH  = AngleWidthDef
) (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        start_i,
  output logic                       busy_o,
  input  wire signed [POS_WIDTH-1:0] agent_x_i,
  input  wire signed [POS_WIDTH-1:0] agent_y_i,
  input  wire signed [POS_WIDTH-1:0] goal_x_i,
  input  wire signed [POS_WIDTH-1:0] goal_y_i,
  input  wire signed [14:0]          agent_heading_i,
  input  wire signed [15:0]          agent_spin_i,
  output logic                       done_o,
  output logic signed [15:0]         angular_accel_o,
  output logic signed [14:0]         wanted_heading_o,
  output logic [1:0]                 steer_status_o,
  input  wire                        psel,
  input  wire                        penable,
  input  wire                        pwrite,
  input  wire  [4:0]                 paddr,
  input  wire  [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  localparam int Steps = (CORDIC_STEPS > TabLen) ? TabLen : CORDIC_STEPS;
  localparam int XW = POS_WIDTH + 16 + 3;
  localparam int ZW = ANGLE_WIDTH + 4;
  localparam logic signed [ZW-1:0] PiZ =
      ZW'(rshift_c(PiQ30, 30 - ANGLE_WIDTH));

  // configuration registers
  logic [14:0] max_acc_q, max_spin_q, arrive_q, slow_q, ttt_q;
  logic wr;
  assign wr = psel & penable & pwrite;
  assign pready = 1'b1;
  assign busy_o = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_acc_q <= 15'd8192; max_spin_q <= 15'd8192; arrive_q <= 15'd41;
      slow_q <= 15'd1024; ttt_q <= 15'd410;
    end else if (wr) begin
      case (paddr[4:2])
        RegMaxAccel: max_acc_q <= pwdata[14:0];
        RegMaxSpin:  max_spin_q <= pwdata[14:0];
        RegArrive:   arrive_q <= pwdata[14:0];
        RegSlow:     slow_q <= pwdata[14:0];
        RegTtt:      ttt_q <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      RegMaxAccel: prdata = {17'd0, max_acc_q};
      RegMaxSpin:  prdata = {17'd0, max_spin_q};
      RegArrive:   prdata = {17'd0, arrive_q};
      RegSlow:     prdata = {17'd0, slow_q};
      RegTtt:      prdata = {17'd0, ttt_q};
      default:     prdata = 32'd0;
    endcase
  end

  // prerotate into the right half plane; side carries heading, spin, zero flag
  logic signed [POS_WIDTH:0] dx, dy;
  logic signed [XW-1:0] x0, y0, xc [Steps+1], yc [Steps+1];
  logic signed [ZW-1:0] z0, zc [Steps+1];
  logic [31:0] sc [Steps+1];
  logic vc [Steps+1];
  assign dx = {goal_x_i[POS_WIDTH-1], goal_x_i} - {agent_x_i[POS_WIDTH-1], agent_x_i};
  assign dy = {goal_y_i[POS_WIDTH-1], goal_y_i} - {agent_y_i[POS_WIDTH-1], agent_y_i};

  always_comb begin
    logic signed [XW-1:0] xi, yi;
    xi = XW'(dy) <<< 16;
    yi = -(XW'(dx) <<< 16);
    if (xi < 0) begin
      z0 = (yi >= 0) ? PiZ : -PiZ;
      x0 = -xi; y0 = -yi;
    end else begin
      z0 = '0; x0 = xi; y0 = yi;
    end
  end

  assign vc[0] = start_i;
  assign xc[0] = x0; assign yc[0] = y0; assign zc[0] = z0;
  assign sc[0] = {agent_heading_i, agent_spin_i, (dx == 0 && dy == 0)};

  for (genvar i = 0; i < Steps; i++) begin : g_cordic
    ftr_cordic_cell #(.XW(XW), .ZW(ZW), .SHIFT(i), .AngleWidth(ANGLE_WIDTH),
                      .SW(32)) u_cell (
      .clk_i, .rst_ni, .vld_i(vc[i]), .x_i(xc[i]), .y_i(yc[i]), .z_i(zc[i]),
      .side_i(sc[i]), .vld_o(vc[i+1]), .x_o(xc[i+1]), .y_o(yc[i+1]),
      .z_o(zc[i+1]), .side_o(sc[i+1]));
  end

  // round, clamp, wrap error
  logic signed [15:0] want;
  logic signed [17:0] err;
  logic [16:0] size;
  logic zero_f, arrive_f, full_f;
  logic signed [14:0] head;
  logic signed [15:0] spin;
  localparam int RS = ANGLE_WIDTH - 12;
  always_comb begin
    logic signed [ZW-1:0] t;
    t = (RS == 0) ? zc[Steps] : ((zc[Steps] + (ZW'(1) <<< (RS > 0 ? RS-1 : 0))) >>> RS);
    if (t > ZW'(PiQ12)) want = PiQ12;
    else if (t < -ZW'(PiQ12)) want = -PiQ12;
    else want = 16'(t);
    head = sc[Steps][31:17];
    spin = sc[Steps][16:1];
    zero_f = sc[Steps][0];
    err = 18'(want) - 18'(head);
    if (err > 18'(PiQ12)) err = err - 18'(TwoPiQ12);
    else if (err < -18'(PiQ12)) err = err + 18'(TwoPiQ12);
    size = err[17] ? 17'(-err) : 17'(err);
    arrive_f = (size < {2'b0, arrive_q});
    full_f = (slow_q == 0) || (size > {2'b0, slow_q});
  end

  // stage A: ramp divide max_spin*size / slow_q (32 bit dividend)
  logic [31:0] ramp_num;
  assign ramp_num = 32'(max_spin_q) * 32'(size);
  localparam int SA = 64;
  logic [SA-1:0] sa [33];
  logic [31:0] na [33];
  logic [15:0] ra [33];
  logic [14:0] da [33];
  logic va [33];
  assign va[0] = vc[Steps];
  assign na[0] = ramp_num; assign ra[0] = '0; assign da[0] = slow_q;
  assign sa[0] = {13'd0, full_f, arrive_f, zero_f, err[17], (err == 0), want[14:0],
                  spin, max_spin_q};
  for (genvar i = 0; i < 32; i++) begin : g_ramp
    ftr_div_cell #(.NW(32), .DW(15), .SW(SA)) u_cell (
      .clk_i, .rst_ni, .vld_i(va[i]), .num_i(na[i]), .rem_i(ra[i]), .den_i(da[i]),
      .side_i(sa[i]), .vld_o(va[i+1]), .num_o(na[i+1]), .rem_o(ra[i+1]),
      .den_o(da[i+1]), .side_o(sa[i+1]));
  end

  // wanted spin and difference
  logic [SA-1:0] s2;
  logic [15:0] mag;
  logic signed [17:0] tgt, diff;
  logic [16:0] ad;
  assign s2 = sa[32];
  always_comb begin
    mag = s2[50] ? {1'b0, s2[14:0]} : na[32][15:0];
    if (s2[46]) tgt = '0;
    else if (s2[47]) tgt = -18'(mag);
    else tgt = 18'(mag);
    diff = tgt - 18'($signed(s2[30:15]));
    ad = diff[17] ? 17'(-diff) : 17'(diff);
  end

  // stage B: ad*4096 / ttt_q
  localparam int SB = 64;
  logic [SB-1:0] sb [30];
  logic [28:0] nb [30];
  logic [15:0] rb [30];
  logic [14:0] db [30];
  logic vb [30];
  assign vb[0] = va[32];
  assign nb[0] = {ad, 12'd0}; assign rb[0] = '0; assign db[0] = ttt_q;
  assign sb[0] = {24'd0, (diff == 0), diff[17], s2[48], s2[49], s2[45:31], max_acc_q,
                  ttt_q == 0, 5'd0};
  for (genvar i = 0; i < 29; i++) begin : g_acc
    ftr_div_cell #(.NW(29), .DW(15), .SW(SB)) u_cell (
      .clk_i, .rst_ni, .vld_i(vb[i]), .num_i(nb[i]), .rem_i(rb[i]), .den_i(db[i]),
      .side_i(sb[i]), .vld_o(vb[i+1]), .num_o(nb[i+1]), .rem_o(rb[i+1]),
      .den_o(db[i+1]), .side_o(sb[i+1]));
  end

  // clamp and register result
  logic [SB-1:0] s3;
  logic [14:0] macc;
  logic [28:0] q;
  logic done_q;
  logic signed [15:0] acc_q;
  logic signed [14:0] head_q;
  logic [1:0] stat_q;
  assign s3 = sb[29];
  assign macc = s3[20:6];
  always_comb begin
    if (s3[5]) q = s3[39] ? '0 : 29'(macc);
    else q = nb[29];
    if (q > 29'(macc)) q = 29'(macc);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) done_q <= 1'b0;
    else done_q <= vb[29];
  end

  always_ff @(posedge clk_i) begin
    if (s3[37]) begin
      stat_q <= StatZero; acc_q <= '0; head_q <= '0;
    end else if (s3[36]) begin
      stat_q <= StatArrive; acc_q <= '0; head_q <= s3[21 +: 15];
    end else begin
      stat_q <= StatSteer; head_q <= s3[21 +: 15];
      acc_q <= s3[38] ? -16'(q) : 16'(q);
    end
  end

  assign done_o = done_q;
  assign angular_accel_o = acc_q;
  assign wanted_heading_o = head_q;
  assign steer_status_o = stat_q;

endmodule
`default_nettype wire
